@@ src/tsc_pkg.sv @@
// Package for the tuner seek controller: codes, register and word types.
`timescale 1ns / 1ps
package tsc_pkg;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_MEAS  = 2'd1,
        MODE_TICK  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_TUNE     = 2'd0,
        ST_FOUND    = 2'd1,
        ST_NOTFOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_BAND_MIN  = 3'd0,
        CFG_BAND_MAX  = 3'd1,
        CFG_STEP      = 3'd2,
        CFG_RSSI_THR  = 3'd3,
        CFG_SNR_THR   = 3'd4,
        CFG_STA_LIMIT = 3'd5,
        CFG_TIMEOUT   = 3'd6
    } t_cfg_idx;

    localparam logic [15:0] RST_BAND_MIN  = 16'd8400;
    localparam logic [15:0] RST_BAND_MAX  = 16'd10800;
    localparam logic [9:0]  RST_STEP      = 10'd10;
    localparam logic [6:0]  RST_RSSI_THR  = 7'd15;
    localparam logic [6:0]  RST_SNR_THR   = 7'd8;
    localparam logic [15:0] RST_STA_LIMIT = 16'd241;
    localparam logic [23:0] RST_TIMEOUT   = 24'd300000;

    typedef struct packed {
        logic [15:0] band_min;
        logic [15:0] band_max;
        logic [9:0]  channel_step;
        logic [6:0]  rssi_threshold;
        logic [6:0]  snr_threshold;
        logic [15:0] station_limit;
        logic [23:0] timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  mode;
        logic        seek_up;
        logic [15:0] start_freq;
        logic [6:0]  rssi;
        logic [6:0]  snr;
    } t_item;

    typedef struct packed {
        logic        valid;
        logic [15:0] tune_freq;
        logic [1:0]  status;
    } t_result;

endpackage

@@ src/tsc_if.sv @@
// Channel interfaces: seek input words, result words and register writes.
`timescale 1ns / 1ps
interface tsc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        seek_up;
    logic [15:0] start_freq;
    logic [6:0]  rssi;
    logic [6:0]  snr;
    modport source (output valid, mode, seek_up, start_freq, rssi, snr, input ready);
    modport sink (input valid, mode, seek_up, start_freq, rssi, snr, output ready);
endinterface

interface tsc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] tune_freq;
    logic [1:0]  status;
    modport source (output valid, tune_freq, status, input ready);
    modport sink (input valid, tune_freq, status, output ready);
endinterface

interface tsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ src/tuner_seek_controller.sv @@
// Top level of the tuner seek controller: register file, input and result registers.
//
// Usage: i_seek takes words of three kinds: start (start frequency and
// direction), measurement report (RSSI and SNR at the tuned channel) and
// one millisecond tick. Each start or accepted report while a seek runs
// yields one word on o_result: the next frequency to tune (status tune),
// the station found, or the start frequency when the seek gives up.
// Ticks and reports while idle yield nothing.
// i_cfg writes the seven registers by index and is always ready; it must be
// written only while no seek word is in flight, which the block does not enforce.
// Path: a word is registered in the input register at accept, worked by the core
// when it moves on, and its result is registered in the output register for o_result.
// Throughput: one word per cycle while o_result is not held; the seek state is
// updated by combinational compare and add logic.
// Reset: registers return to their defaults, the seek is idle and both
// pipeline registers are empty.
// Stall: a held result keeps the word behind it in the input register;
// i_seek.ready drops only when both registers are full.
`timescale 1ns / 1ps
module tuner_seek_controller
    import tsc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    tsc_in_if.sink     i_seek,
    tsc_cfg_if.sink    i_cfg,
    tsc_out_if.source  o_result
);

    t_cfg        r_cfg;
    logic        r_s1_valid;
    t_item       r_s1_item;
    logic        r_out_valid;
    logic [15:0] r_out_freq;
    logic [1:0]  r_out_status;
    logic        s1_fire;
    t_result     res;

    // config writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{band_min: RST_BAND_MIN, band_max: RST_BAND_MAX,
                       channel_step: RST_STEP, rssi_threshold: RST_RSSI_THR,
                       snr_threshold: RST_SNR_THR, station_limit: RST_STA_LIMIT,
                       timeout_ms: RST_TIMEOUT};
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_BAND_MIN:  r_cfg.band_min       <= i_cfg.data[15:0];
                CFG_BAND_MAX:  r_cfg.band_max       <= i_cfg.data[15:0];
                CFG_STEP:      r_cfg.channel_step   <= i_cfg.data[9:0];
                CFG_RSSI_THR:  r_cfg.rssi_threshold <= i_cfg.data[6:0];
                CFG_SNR_THR:   r_cfg.snr_threshold  <= i_cfg.data[6:0];
                CFG_STA_LIMIT: r_cfg.station_limit  <= i_cfg.data[15:0];
                CFG_TIMEOUT:   r_cfg.timeout_ms     <= i_cfg.data[23:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline control
    assign s1_fire      = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_seek.ready = !r_s1_valid || s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_seek.ready) begin
            r_s1_valid <= i_seek.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_seek.ready && i_seek.valid) begin
            r_s1_item <= '{mode: i_seek.mode, seek_up: i_seek.seek_up,
                           start_freq: i_seek.start_freq, rssi: i_seek.rssi,
                           snr: i_seek.snr};
        end
    end

    tsc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_item  (r_s1_item),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_result.ready) begin
            r_out_valid <= s1_fire && res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && res.valid) begin
            r_out_freq   <= res.tune_freq;
            r_out_status <= res.status;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.tune_freq = r_out_freq;
    assign o_result.status    = r_out_status;

endmodule

@@ src/tsc_core.sv @@
// Seek state and next-channel logic, one word per enabled cycle.
`timescale 1ns / 1ps
module tsc_core
    import tsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    logic [15:0] r_origin, n_origin;
    logic [15:0] r_probe, n_probe;
    logic [15:0] r_tried, n_tried;
    logic [23:0] r_elapsed, n_elapsed;
    logic        r_up, n_up;
    logic        r_busy, n_busy;

    always_comb begin
        logic [15:0] probe;
        logic [15:0] origin;
        logic        up;
        logic [16:0] sum;
        logic [15:0] diff;
        logic        at_limit;
        logic [15:0] tried_inc;
        logic        do_adv;

        n_origin  = r_origin;
        n_probe   = r_probe;
        n_tried   = r_tried;
        n_elapsed = r_elapsed;
        n_up      = r_up;
        n_busy    = r_busy;
        o_res     = '0;
        do_adv    = 1'b0;

        if (i_item.mode == MODE_START) begin
            probe  = i_item.start_freq;
            origin = i_item.start_freq;
            up     = i_item.seek_up;
        end else begin
            probe  = r_probe;
            origin = r_origin;
            up     = r_up;
        end

        sum  = {1'b0, probe} + {7'd0, i_cfg.channel_step};
        diff = probe - {6'd0, i_cfg.channel_step};
        if (up) begin
            at_limit = sum > {1'b0, i_cfg.band_max};
        end else begin
            at_limit = (probe < {6'd0, i_cfg.channel_step}) || (diff < i_cfg.band_min);
        end

        tried_inc = (r_tried != 16'hFFFF) ? r_tried + 16'd1 : r_tried;

        unique case (i_item.mode)
            MODE_START: begin
                n_origin  = origin;
                n_probe   = probe;
                n_up      = up;
                n_tried   = '0;
                n_elapsed = '0;
                n_busy    = 1'b1;
                do_adv    = 1'b1;
            end
            MODE_MEAS: begin
                if (r_busy) begin
                    if (i_item.rssi >= i_cfg.rssi_threshold &&
                        i_item.snr >= i_cfg.snr_threshold) begin
                        n_busy = 1'b0;
                        o_res  = '{valid: 1'b1, tune_freq: r_probe, status: ST_FOUND};
                    end else begin
                        n_tried = tried_inc;
                        if (r_probe == r_origin || tried_inc >= i_cfg.station_limit ||
                            r_elapsed > i_cfg.timeout_ms) begin
                            n_busy = 1'b0;
                            o_res  = '{valid: 1'b1, tune_freq: r_origin,
                                       status: ST_NOTFOUND};
                        end else begin
                            do_adv = 1'b1;
                        end
                    end
                end
            end
            MODE_TICK: begin
                if (r_busy && r_elapsed != 24'hFFFFFF) begin
                    n_elapsed = r_elapsed + 24'd1;
                end
            end
            default: begin
            end
        endcase

        if (do_adv) begin
            if (at_limit) begin
                n_busy = 1'b0;
                o_res  = '{valid: 1'b1, tune_freq: origin, status: ST_NOTFOUND};
            end else begin
                n_probe = up ? sum[15:0] : diff;
                o_res   = '{valid: 1'b1, tune_freq: n_probe, status: ST_TUNE};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin  <= '0;
            r_probe   <= '0;
            r_tried   <= '0;
            r_elapsed <= '0;
            r_up      <= 1'b0;
            r_busy    <= 1'b0;
        end else if (i_fire) begin
            r_origin  <= n_origin;
            r_probe   <= n_probe;
            r_tried   <= n_tried;
            r_elapsed <= n_elapsed;
            r_up      <= n_up;
            r_busy    <= n_busy;
        end
    end

endmodule
